FILE: rtl/vtpa_pkg.sv
package vtpa_pkg;

    // Pixel size of one square CTU in the packed picture.
    localparam int CTU_SIZE       = 64;
    // Most window tiles served for one request.
    localparam int MAX_VIEW_TILES = 64;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 14;
    localparam int GRID_W       = 8;
    localparam int VIEW_W       = 7;
    localparam int TILE_W       = 14;
    localparam int TOTAL_W      = 2 * GRID_W;
    localparam int COUNT_W      = 2 * VIEW_W;
    localparam int PACKED_W_W   = TILE_W + VIEW_W;
    localparam int CTU_SHIFT    = $clog2(CTU_SIZE);
    localparam int TILE_CTU_W   = TILE_W - CTU_SHIFT;
    localparam int PACKED_CTU_W = PACKED_W_W - CTU_SHIFT;
    localparam int ROW_CTU_W    = TILE_CTU_W + PACKED_CTU_W;
    localparam int REGION_W     = $clog2(MAX_VIEW_TILES);
    localparam int Y_ACC_W      = ROW_CTU_W + REGION_W;
    localparam int X_ACC_W      = TILE_CTU_W + REGION_W;
    localparam int PIX_ACC_W    = TILE_W + REGION_W;
    localparam int OUT_W        = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_COLS   = 3'd0,
        REG_GRID_ROWS   = 3'd1,
        REG_VIEW_COLS   = 3'd2,
        REG_VIEW_ROWS   = 3'd3,
        REG_TILE_WIDTH  = 3'd4,
        REG_TILE_HEIGHT = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        MOD_TOTAL     = 1'b0,
        MOD_GRID_COLS = 1'b1
    } mod_sel_t;

    typedef struct packed {
        logic     capture;
        logic     mod_go;
        mod_sel_t mod_sel;
        logic     init;
        logic     step;
    } vtpa_cmd_t;

    typedef struct packed {
        logic mod_done;
        logic last;
    } vtpa_status_t;

endpackage

FILE: rtl/vtpa_mod.sv
module vtpa_mod
    import vtpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic [GRID_W-1:0]    dividend,
    input  logic [TOTAL_W-1:0]   divisor,
    output logic                 done,
    output logic [GRID_W-1:0]    rem
);

    localparam int CNT_W = $clog2(GRID_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [GRID_W-1:0]  rem_reg;
    logic [GRID_W-1:0]  dq_reg;

    logic [GRID_W:0]    shifted;
    logic [TOTAL_W-1:0] shifted_ext;
    logic [TOTAL_W-1:0] diff;
    logic               take;

    // One restoring step per cycle, most significant dividend bit first.
    // The partial remainder never exceeds the dividend, so it fits in
    // the dividend's width.
    always_comb
    begin
        shifted     = {rem_reg, dq_reg[GRID_W-1]};
        shifted_ext = TOTAL_W'(shifted);
        take        = (shifted_ext >= divisor);
        diff        = shifted_ext - divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(GRID_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[GRID_W-1:0] : shifted[GRID_W-1:0];
            dq_reg  <= {dq_reg[GRID_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/vtpa_dp.sv
module vtpa_dp
    import vtpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [GRID_W-1:0]     start_tile,
    input  vtpa_cmd_t             cmd,
    output vtpa_status_t          status,
    output logic [GRID_W-1:0]     source_tile,
    output logic [OUT_W-1:0]      dest_ctu_index,
    output logic [OUT_W-1:0]      packed_top,
    output logic [OUT_W-1:0]      packed_left,
    output logic                  last_region
);

    // Configuration registers.
    logic [GRID_W-1:0] grid_cols_reg;
    logic [GRID_W-1:0] grid_rows_reg;
    logic [VIEW_W-1:0] view_cols_reg;
    logic [VIEW_W-1:0] view_rows_reg;
    logic [TILE_W-1:0] tile_width_reg;
    logic [TILE_W-1:0] tile_height_reg;

    // Per-request set-up values.
    logic [GRID_W-1:0]     start_in_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [PACKED_W_W-1:0] packed_w_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [ROW_CTU_W-1:0]  row_ctus_reg;
    mod_sel_t              sel_reg;
    logic [GRID_W-1:0]     start_reg;
    logic [GRID_W-1:0]     col0_reg;
    logic [TOTAL_W-1:0]    base0_reg;

    // Walk state.
    logic [REGION_W-1:0]   r_reg;
    logic [REGION_W-1:0]   y_reg;
    logic [TOTAL_W-1:0]    row_base_reg;
    logic [GRID_W-1:0]     colpos_reg;
    logic [Y_ACC_W-1:0]    y_ctu_reg;
    logic [X_ACC_W-1:0]    x_ctu_reg;
    logic [PIX_ACC_W-1:0]  top_reg;
    logic [PIX_ACC_W-1:0]  left_reg;

    // Output word.
    logic [GRID_W-1:0]     source_tile_reg;
    logic [OUT_W-1:0]      dest_ctu_reg;
    logic [OUT_W-1:0]      packed_top_reg;
    logic [OUT_W-1:0]      packed_left_reg;
    logic                  last_reg;

    logic [GRID_W-1:0]       gc;
    logic [GRID_W-1:0]       gr;
    logic [VIEW_W-1:0]       vc;
    logic [VIEW_W-1:0]       vr;
    logic [VIEW_W-1:0]       vr_m1;
    logic [TILE_CTU_W-1:0]   col_ctus;
    logic [TILE_CTU_W-1:0]   th_ctus;
    logic [PACKED_CTU_W-1:0] pw_ctus;
    logic [COUNT_W-1:0]      count_cap;
    logic [REGION_W-1:0]     cnt_m1;
    logic                    y_wrap;
    logic [TOTAL_W:0]        rb_sum;
    logic [TOTAL_W-1:0]      rb_next;
    logic [GRID_W:0]         col_inc;
    logic [TOTAL_W:0]        src_sum;
    logic [Y_ACC_W:0]        ctu_sum;

    logic                    mod_done;
    logic [GRID_W-1:0]       mod_rem;
    logic [GRID_W-1:0]       mod_dividend;
    logic [TOTAL_W-1:0]      mod_divisor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg   <= GRID_W'(1);
            grid_rows_reg   <= GRID_W'(1);
            view_cols_reg   <= VIEW_W'(1);
            view_rows_reg   <= VIEW_W'(1);
            tile_width_reg  <= TILE_W'(CTU_SIZE);
            tile_height_reg <= TILE_W'(CTU_SIZE);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GRID_COLS:   grid_cols_reg   <= cfg_data[GRID_W-1:0];
                REG_GRID_ROWS:   grid_rows_reg   <= cfg_data[GRID_W-1:0];
                REG_VIEW_COLS:   view_cols_reg   <= cfg_data[VIEW_W-1:0];
                REG_VIEW_ROWS:   view_rows_reg   <= cfg_data[VIEW_W-1:0];
                REG_TILE_WIDTH:  tile_width_reg  <= cfg_data[TILE_W-1:0];
                REG_TILE_HEIGHT: tile_height_reg <= cfg_data[TILE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        // A zero count register is used as one.
        gc       = (grid_cols_reg == '0) ? GRID_W'(1) : grid_cols_reg;
        gr       = (grid_rows_reg == '0) ? GRID_W'(1) : grid_rows_reg;
        vc       = (view_cols_reg == '0) ? VIEW_W'(1) : view_cols_reg;
        vr       = (view_rows_reg == '0) ? VIEW_W'(1) : view_rows_reg;
        vr_m1    = vr - 1'b1;
        col_ctus = TILE_CTU_W'(tile_width_reg / CTU_SIZE);
        th_ctus  = TILE_CTU_W'(tile_height_reg / CTU_SIZE);
        pw_ctus  = PACKED_CTU_W'(packed_w_reg / CTU_SIZE);

        count_cap = (count_reg > COUNT_W'(MAX_VIEW_TILES)) ?
                    COUNT_W'(MAX_VIEW_TILES) : count_reg;
        cnt_m1    = REGION_W'(count_cap - 1'b1);

        y_wrap  = ({1'b0, y_reg} == vr_m1);
        rb_sum  = {1'b0, row_base_reg} + (TOTAL_W + 1)'(gc);
        rb_next = (rb_sum >= {1'b0, total_reg}) ?
                  TOTAL_W'(rb_sum - {1'b0, total_reg}) : rb_sum[TOTAL_W-1:0];
        col_inc = {1'b0, colpos_reg} + 1'b1;

        src_sum = {1'b0, row_base_reg} + (TOTAL_W + 1)'(colpos_reg);
        ctu_sum = {1'b0, y_ctu_reg} + (Y_ACC_W + 1)'(x_ctu_reg);

        // The dividend is loaded on the start cycle; the divisor is read on
        // every step, so it follows the operation that is running.
        mod_dividend = (cmd.mod_sel == MOD_TOTAL) ? start_in_reg : start_reg;
        mod_divisor  = (sel_reg == MOD_TOTAL) ? total_reg : TOTAL_W'(gc);
    end

    vtpa_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.mod_go),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            start_in_reg <= start_tile;
            total_reg    <= gc * gr;
            packed_w_reg <= tile_width_reg * vc;
            count_reg    <= vc * vr;
        end

        if (cmd.mod_go)
        begin
            sel_reg <= cmd.mod_sel;
            if (cmd.mod_sel == MOD_GRID_COLS)
            begin
                row_ctus_reg <= th_ctus * pw_ctus;
            end
        end

        if (mod_done)
        begin
            if (sel_reg == MOD_TOTAL)
            begin
                start_reg <= mod_rem;
            end
            else
            begin
                col0_reg <= mod_rem;
            end
        end

        if (cmd.init)
        begin
            // The column offset within a grid row is the same for every
            // window row; only the row's base index moves.
            base0_reg    <= TOTAL_W'(start_reg - col0_reg);
            row_base_reg <= TOTAL_W'(start_reg - col0_reg);
            colpos_reg   <= col0_reg;
            r_reg        <= '0;
            y_reg        <= '0;
            y_ctu_reg    <= '0;
            x_ctu_reg    <= '0;
            top_reg      <= '0;
            left_reg     <= '0;
        end
        else if (cmd.step)
        begin
            r_reg <= r_reg + 1'b1;
            if (y_wrap)
            begin
                y_reg        <= '0;
                row_base_reg <= base0_reg;
                y_ctu_reg    <= '0;
                top_reg      <= '0;
                x_ctu_reg    <= x_ctu_reg + X_ACC_W'(col_ctus);
                left_reg     <= left_reg + PIX_ACC_W'(tile_width_reg);
                colpos_reg   <= (col_inc == (GRID_W + 1)'(gc)) ?
                                '0 : col_inc[GRID_W-1:0];
            end
            else
            begin
                y_reg        <= y_reg + 1'b1;
                row_base_reg <= rb_next;
                y_ctu_reg    <= y_ctu_reg + Y_ACC_W'(row_ctus_reg);
                top_reg      <= top_reg + PIX_ACC_W'(tile_height_reg);
            end

            source_tile_reg <= (|src_sum[TOTAL_W:GRID_W]) ?
                               '1 : src_sum[GRID_W-1:0];
            dest_ctu_reg    <= (|ctu_sum[Y_ACC_W:OUT_W]) ?
                               '1 : ctu_sum[OUT_W-1:0];
            packed_top_reg  <= (|top_reg[PIX_ACC_W-1:OUT_W]) ?
                               '1 : top_reg[OUT_W-1:0];
            packed_left_reg <= (|left_reg[PIX_ACC_W-1:OUT_W]) ?
                               '1 : left_reg[OUT_W-1:0];
            last_reg        <= (r_reg == cnt_m1);
        end
    end

    assign status.mod_done = mod_done;
    assign status.last     = (r_reg == cnt_m1);

    assign source_tile    = source_tile_reg;
    assign dest_ctu_index = dest_ctu_reg;
    assign packed_top     = packed_top_reg;
    assign packed_left    = packed_left_reg;
    assign last_region    = last_reg;

endmodule

FILE: rtl/vtpa_ctrl.sv
module vtpa_ctrl
    import vtpa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  vtpa_status_t status,
    output vtpa_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_WAIT_START,
        S_GO_COL,
        S_WAIT_COL,
        S_INIT,
        S_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd.capture = (state_reg == S_IDLE) && in_valid;
        cmd.mod_go  = (state_reg == S_SETUP) || (state_reg == S_GO_COL);
        cmd.mod_sel = (state_reg == S_GO_COL) ? MOD_GRID_COLS : MOD_TOTAL;
        cmd.init    = (state_reg == S_INIT);
        // The output register takes a new word when it is empty or its
        // word leaves in this cycle.
        cmd.step    = (state_reg == S_RUN) && (!out_valid_reg || !out_stall);

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:      state_next = S_WAIT_START;
            S_WAIT_START:
            begin
                if (status.mod_done)
                begin
                    state_next = S_GO_COL;
                end
            end
            S_GO_COL:     state_next = S_WAIT_COL;
            S_WAIT_COL:
            begin
                if (status.mod_done)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:       state_next = S_RUN;
            S_RUN:
            begin
                if (cmd.step && status.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase

        if (cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/viewport_tile_packing_addresser_top.sv
// Viewport tile packing addresser.
//
// Input channel (in_valid, in_stall, start_tile): one word names the grid
// tile at the top-left of the viewport window. in_stall is high from the
// cycle after a word is taken until the last result word of that request
// has been loaded into the output register.
// Output channel (out_valid, out_stall, result fields): one word per window
// tile in column-major order, at most MAX_VIEW_TILES words, with last_region set on the final one.
// Configuration is written through cfg_we, cfg_index and cfg_data while
// the block is idle; indexes beyond the register list are ignored.
//
// Timing: after a request is taken, set-up runs two 8-step remainder
// operations in a shared bit-serial unit before the first result word is
// loaded. Then one word per cycle while the output is not stalled. A stall
// holds the output word and pauses the walk. Reset returns the configuration
// and control registers to their reset values and leaves the block idle
// with no word pending.
module viewport_tile_packing_addresser_top
    import vtpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [GRID_W-1:0]     start_tile,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [GRID_W-1:0]     source_tile,
    output logic [OUT_W-1:0]      dest_ctu_index,
    output logic [OUT_W-1:0]      packed_top,
    output logic [OUT_W-1:0]      packed_left,
    output logic                  last_region
);

    vtpa_cmd_t    cmd;
    vtpa_status_t status;

    vtpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    vtpa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start_tile     (start_tile),
        .cmd            (cmd),
        .status         (status),
        .source_tile    (source_tile),
        .dest_ctu_index (dest_ctu_index),
        .packed_top     (packed_top),
        .packed_left    (packed_left),
        .last_region    (last_region)
    );

endmodule

FILE: rtl/vtpa_checker.sv
module vtpa_checker
    import vtpa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [GRID_W-1:0] source_tile,
    input logic [OUT_W-1:0]  dest_ctu_index,
    input logic [OUT_W-1:0]  packed_top,
    input logic [OUT_W-1:0]  packed_left,
    input logic              last_region
);

    // A stalled output word stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(source_tile) &&
        $stable(dest_ctu_index) && $stable(packed_top) &&
        $stable(packed_left) && $stable(last_region))
        else $error("stalled output word changed");

    // Taking a request makes the block busy.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block not busy after taking a request");

    // While a word other than the last is pending, the request is still open.
    a_busy_mid_request: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_region |-> in_stall)
        else $error("block idle with a request half delivered");

    // Once idle, the only word that can still wait is a final one.
    a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_stall |-> last_region)
        else $error("idle block holds a word that is not final");

endmodule

bind viewport_tile_packing_addresser_top vtpa_checker u_vtpa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .source_tile    (source_tile),
    .dest_ctu_index (dest_ctu_index),
    .packed_top     (packed_top),
    .packed_left    (packed_left),
    .last_region    (last_region)
);

FILE: sim/tb_viewport_tile_packing_addresser_top.sv
module tb_viewport_tile_packing_addresser_top;
    import vtpa_pkg::*;

    localparam int RUN_LIMIT     = 4_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_WORDS  = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int DIR_ROWS      = 17;

    // The block ignores writes to the two indexes past the register list.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [GRID_W-1:0] src;
        logic [OUT_W-1:0]  ctu;
        logic [OUT_W-1:0]  top;
        logic [OUT_W-1:0]  left;
        logic              last;
    } tile_region_t;

    typedef struct packed {
        logic [GRID_W-1:0] gc;
        logic [GRID_W-1:0] gr;
        logic [VIEW_W-1:0] vc;
        logic [VIEW_W-1:0] vr;
        logic [TILE_W-1:0] tw;
        logic [TILE_W-1:0] th;
        logic [GRID_W-1:0] start;
        logic              typed;
        logic [GRID_W-1:0] want_src;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [GRID_W-1:0]     start_tile = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [GRID_W-1:0]     source_tile;
    logic [OUT_W-1:0]      dest_ctu_index;
    logic [OUT_W-1:0]      packed_top;
    logic [OUT_W-1:0]      packed_left;
    logic                  last_region;

    // Shadow copy of the configuration registers.
    logic [GRID_W-1:0] grid_cols_q = 8'd1;
    logic [GRID_W-1:0] grid_rows_q = 8'd1;
    logic [VIEW_W-1:0] view_cols_q = 7'd1;
    logic [VIEW_W-1:0] view_rows_q = 7'd1;
    logic [TILE_W-1:0] tile_w_q    = 14'd64;
    logic [TILE_W-1:0] tile_h_q    = 14'd64;

    tile_region_t expected_regions[$];
    int           mismatches = 0;
    int           cycle_count = 0;
    bit           quiet = 1'b0;

    // Directed rows. Typed rows are single-tile windows whose result is all
    // zero apart from the source tile and the last mark.
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{8'd1,   8'd1,   7'd1,   7'd1,   14'd64,    14'd64,    8'd0,   1'b1, 8'd0},
        '{8'd1,   8'd1,   7'd1,   7'd1,   14'd64,    14'd64,    8'd255, 1'b1, 8'd0},
        '{8'd255, 8'd1,   7'd1,   7'd1,   14'd8192,  14'd8192,  8'd254, 1'b1, 8'd254},
        '{8'd255, 8'd1,   7'd1,   7'd1,   14'd8192,  14'd8192,  8'd255, 1'b1, 8'd0},
        '{8'd0,   8'd0,   7'd0,   7'd0,   14'd0,     14'd0,     8'd128, 1'b1, 8'd0},
        '{8'd16,  8'd16,  7'd1,   7'd1,   14'd64,    14'd64,    8'd255, 1'b1, 8'd255},
        '{8'd16,  8'd16,  7'd8,   7'd8,   14'd64,    14'd64,    8'd0,   1'b0, 8'd0},
        '{8'd16,  8'd16,  7'd8,   7'd8,   14'd128,   14'd192,   8'd255, 1'b0, 8'd0},
        '{8'd255, 8'd2,   7'd1,   7'd2,   14'd64,    14'd64,    8'd10,  1'b0, 8'd0},
        '{8'd255, 8'd255, 7'd64,  7'd64,  14'd8192,  14'd8192,  8'd123, 1'b0, 8'd0},
        '{8'd255, 8'd255, 7'd127, 7'd127, 14'd16383, 14'd16383, 8'd170, 1'b0, 8'd0},
        '{8'd7,   8'd5,   7'd3,   7'd4,   14'd100,   14'd190,   8'd34,  1'b0, 8'd0},
        '{8'd2,   8'd9,   7'd3,   7'd4,   14'd64,    14'd128,   8'd9,   1'b0, 8'd0},
        '{8'd1,   8'd255, 7'd1,   7'd64,  14'd64,    14'd64,    8'd200, 1'b0, 8'd0},
        '{8'd255, 8'd255, 7'd64,  7'd1,   14'd1000,  14'd64,    8'd85,  1'b0, 8'd0},
        '{8'd0,   8'd3,   7'd2,   7'd0,   14'd320,   14'd448,   8'd7,   1'b0, 8'd0},
        '{8'd9,   8'd9,   7'd9,   7'd7,   14'd6400,  14'd64,    8'd80,  1'b0, 8'd0}
    };

    viewport_tile_packing_addresser_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_tile     (start_tile),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .source_tile    (source_tile),
        .dest_ctu_index (dest_ctu_index),
        .packed_top     (packed_top),
        .packed_left    (packed_left),
        .last_region    (last_region)
    );

    always #6 clk = ~clk;

    function automatic longint unsigned clip(input longint unsigned v,
                                             input longint unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // Queues every region the window starting at start_word produces under
    // the current configuration, in column-major order.
    function automatic void predict_window(input logic [GRID_W-1:0] start_word);
        longint unsigned gc, gr, vc, vr, total, first, count;
        longint unsigned row_ctus, col_ctus, y, x, row_start, src;
        tile_region_t    w;
        gc = (grid_cols_q == 0) ? 1 : grid_cols_q;
        gr = (grid_rows_q == 0) ? 1 : grid_rows_q;
        vc = (view_cols_q == 0) ? 1 : view_cols_q;
        vr = (view_rows_q == 0) ? 1 : view_rows_q;
        total = gc * gr;
        first = start_word % total;
        count = vc * vr;
        if (count > MAX_VIEW_TILES)
            count = MAX_VIEW_TILES;
        col_ctus = tile_w_q / CTU_SIZE;
        row_ctus = (tile_h_q / CTU_SIZE) * ((tile_w_q * vc) / CTU_SIZE);
        for (longint unsigned r = 0; r < count; r++)
        begin
            y = r % vr;
            x = r / vr;
            // A row start wraps over the whole grid, a column within its row.
            row_start = (first + y * gc) % total;
            src = (row_start / gc) * gc + ((row_start % gc) + x) % gc;
            w.src  = GRID_W'(clip(src, 255));
            w.ctu  = OUT_W'(clip(y * row_ctus + x * col_ctus, 65535));
            w.top  = OUT_W'(clip(y * tile_h_q, 65535));
            w.left = OUT_W'(clip(x * tile_w_q, 65535));
            w.last = (r + 1 == count);
            expected_regions = {expected_regions, w};
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [GRID_W-1:0] gc, input logic [GRID_W-1:0] gr,
                                input logic [VIEW_W-1:0] vc, input logic [VIEW_W-1:0] vr,
                                input logic [TILE_W-1:0] tw, input logic [TILE_W-1:0] th);
        write_reg(REG_GRID_COLS,   CFG_DATA_W'(gc));
        write_reg(REG_GRID_ROWS,   CFG_DATA_W'(gr));
        write_reg(REG_VIEW_COLS,   CFG_DATA_W'(vc));
        write_reg(REG_VIEW_ROWS,   CFG_DATA_W'(vr));
        write_reg(REG_TILE_WIDTH,  tw);
        write_reg(REG_TILE_HEIGHT, th);
        write_reg(REG_SPARE_A,     CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B,     CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        grid_cols_q = gc;
        grid_rows_q = gr;
        view_cols_q = vc;
        view_rows_q = vr;
        tile_w_q    = tw;
        tile_h_q    = th;
    endtask

    // Waits until every expected region has come out and the block is idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_regions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_word(input logic [GRID_W-1:0] s, input logic typed,
                             input logic [GRID_W-1:0] want_src);
        int           gap;
        tile_region_t w;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        start_tile <= s;
        do
            @(posedge clk);
        while (in_stall);
        if (typed)
        begin
            w = '{want_src, 16'd0, 16'd0, 16'd0, 1'b1};
            expected_regions = {expected_regions, w};
        end
        else
            predict_window(s);
    endtask

    // Output side: each ready cycle is followed by a random stretch of stall, which may be empty.
    always @(posedge clk)
    begin : stall_gen
        int stall_left;
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = idle_len();
        end
    end

    always @(posedge clk)
    begin : region_check
        tile_region_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_regions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: src=%0d ctu=%0d top=%0d left=%0d last=%0b",
                             source_tile, dest_ctu_index, packed_top, packed_left,
                             last_region);
            end
            else
            begin
                want = expected_regions.pop_front();
                if (source_tile !== want.src || dest_ctu_index !== want.ctu ||
                    packed_top !== want.top || packed_left !== want.left ||
                    last_region !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("mismatch: expected src=%0d ctu=%0d top=%0d left=%0d last=%0b",
                               want.src, want.ctu, want.top, want.left, want.last);
                        $display(", got src=%0d ctu=%0d top=%0d left=%0d last=%0b",
                                 source_tile, dest_ctu_index, packed_top, packed_left,
                                 last_region);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout with %0d regions outstanding", expected_regions.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int       i, k, n, total, random_sent;
        int       gc, gr, vc, vr, tw, th;
        logic [GRID_W-1:0] s;
        dir_row_t row;
        random_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            row = directed_rows[i];
            if ({row.gc, row.gr, row.vc, row.vr, row.tw, row.th} !==
                {grid_cols_q, grid_rows_q, view_cols_q, view_rows_q, tile_w_q, tile_h_q})
            begin
                settle();
                apply_config(row.gc, row.gr, row.vc, row.vr, row.tw, row.th);
            end
            send_word(row.start, row.typed, row.want_src);
        end

        while (random_sent < RANDOM_WORDS)
        begin
            settle();
            if ($urandom_range(0, 9) < 7)
            begin
                // Well-formed set-up: window no wider than the grid and within the tile limit.
                gc = $urandom_range(1, 32);
                gr = $urandom_range(1, 255 / gc);
                vc = $urandom_range(1, (gc < MAX_VIEW_TILES) ? gc : MAX_VIEW_TILES);
                vr = $urandom_range(1, MAX_VIEW_TILES / vc);
                tw = CTU_SIZE * (($urandom_range(0, 4) == 0) ? $urandom_range(1, 128)
                                                           : $urandom_range(1, 4));
                th = CTU_SIZE * (($urandom_range(0, 4) == 0) ? $urandom_range(1, 128)
                                                           : $urandom_range(1, 4));
            end
            else
            begin
                gc = $urandom_range(0, 255);
                gr = $urandom_range(0, 255);
                vc = $urandom_range(0, 127);
                vr = $urandom_range(0, 127);
                tw = $urandom_range(0, 16383);
                th = $urandom_range(0, 16383);
            end
            apply_config(GRID_W'(gc), GRID_W'(gr), VIEW_W'(vc), VIEW_W'(vr),
                         TILE_W'(tw), TILE_W'(th));
            quiet = ($urandom_range(0, 3) == 0);
            total = ((gc == 0) ? 1 : gc) * ((gr == 0) ? 1 : gr);
            n = $urandom_range(8, 30);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 4) != 0 && total <= 256)
                    s = GRID_W'($urandom_range(0, total - 1));
                else
                    s = GRID_W'($urandom);
                send_word(s, 1'b0, '0);
                random_sent++;
            end
        end

        settle();
        if (mismatches == 0 && expected_regions.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
